### rtl/core/rpnsa_pkg.sv
package rpnsa_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // iterations of the shift-add / restoring loops
    localparam int STEPS = DATA_W;
    localparam int CNT_W = $clog2(STEPS);

    // adder width: 33-bit operands plus a sign bit for compares
    localparam int ADD_W = DATA_W + 2;

    // saturation bounds
    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd3;

    // operations of the arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    // core to unit
    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    // unit to core
    typedef struct packed {
        logic done;
        logic sat;
    } alu_resp_t;

endpackage

### rtl/core/rpnsa_ifs.sv
interface rpnsa_in_if;
    logic                                valid;
    logic                                ready;
    logic [rpnsa_pkg::OP_W-1:0]          op;
    logic signed [rpnsa_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface rpnsa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rpnsa_pkg::DATA_W-1:0] x_reg;
    logic signed [rpnsa_pkg::DATA_W-1:0] y_reg;
    logic signed [rpnsa_pkg::DATA_W-1:0] z_reg;
    logic signed [rpnsa_pkg::DATA_W-1:0] t_reg;
    logic [rpnsa_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output x_reg, output y_reg, output z_reg,
                    output t_reg, output status, input ready);
    modport sink   (input valid, input x_reg, input y_reg, input z_reg,
                    input t_reg, input status, output ready);
endinterface

### rtl/core/rpnsa_alu.sv
module rpnsa_alu (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpnsa_pkg::alu_req_t          req,
    input  logic [rpnsa_pkg::DATA_W-1:0] y,
    input  logic [rpnsa_pkg::DATA_W-1:0] x,
    output rpnsa_pkg::alu_resp_t         resp,
    output logic [rpnsa_pkg::DATA_W-1:0] result
);
    import rpnsa_pkg::*;

    typedef enum logic [5:0] {
        A_IDLE   = 6'b000001,
        A_ADDSUB = 6'b000010,
        A_MUL    = 6'b000100,
        A_DPRE   = 6'b001000,
        A_DIV    = 6'b010000,
        A_FIN    = 6'b100000
    } astate_t;

    astate_t               state_reg, state_next;
    alu_op_t               op_reg, op_next;
    logic                  neg_reg, neg_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_W-1:0]     a_reg, a_next;
    logic [2*DATA_W-1:0]   p_reg, p_next;
    logic [DATA_W-1:0]     res_reg, res_next;
    logic                  sat_reg, sat_next;
    logic                  done_reg, done_next;

    logic [ADD_W-1:0]      opa, opb, sum;
    logic                  inv;
    logic [DATA_W-1:0]     y_mag, x_mag;
    logic                  qbit;
    logic [2*DATA_W:0]     prod_s;
    logic [2*DATA_W-FRAC_W:0] prod_sh;
    logic [DATA_W:0]       quo_s;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        mag = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

    assign y_mag = mag(y);
    assign x_mag = mag(x);

    // operand select for the shared adder
    always_comb
    begin
        opa = '0;
        opb = '0;
        inv = 1'b0;
        case (state_reg)
            A_ADDSUB:
            begin
                opa = {{2{p_reg[2*DATA_W-1]}}, p_reg[2*DATA_W-1:DATA_W]};
                opb = {{2{p_reg[DATA_W-1]}}, p_reg[DATA_W-1:0]};
                inv = (op_reg == ALU_SUB);
            end
            A_MUL:
            begin
                opa = {2'b00, p_reg[2*DATA_W-1:DATA_W]};
                opb = p_reg[0] ? {2'b00, a_reg} : '0;
            end
            A_DPRE:
            begin
                opa = {2'b00, p_reg[2*DATA_W-1:DATA_W]};
                opb = {2'b00, a_reg};
                inv = 1'b1;
            end
            A_DIV:
            begin
                opa = {1'b0, p_reg[2*DATA_W-1:DATA_W], p_reg[DATA_W-1]};
                opb = {2'b00, a_reg};
                inv = 1'b1;
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    // shared adder / subtractor
    assign sum = opa + (opb ^ {ADD_W{inv}}) + {{(ADD_W-1){1'b0}}, inv};

    // quotient bit of the restoring step
    assign qbit = ~sum[ADD_W-1];

    // final sign fix of product and quotient
    assign prod_s  = neg_reg ? (~{1'b0, p_reg} + (2*DATA_W+1)'(1)) : {1'b0, p_reg};
    assign prod_sh = prod_s[2*DATA_W:FRAC_W];
    assign quo_s   = neg_reg ? (~{1'b0, p_reg[DATA_W-1:0]} + (DATA_W+1)'(1))
                             : {1'b0, p_reg[DATA_W-1:0]};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        p_next     = p_reg;
        res_next   = res_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    neg_next = y[DATA_W-1] ^ x[DATA_W-1];
                    ovf_next = 1'b0;
                    cnt_next = '0;
                    case (req.op)
                        ALU_MUL:
                        begin
                            a_next     = y_mag;
                            p_next     = {{DATA_W{1'b0}}, x_mag};
                            state_next = A_MUL;
                        end
                        ALU_DIV:
                        begin
                            a_next     = x_mag;
                            p_next     = {{FRAC_W{1'b0}}, y_mag, {FRAC_W{1'b0}}};
                            state_next = A_DPRE;
                        end
                        default:
                        begin
                            p_next     = {y, x};
                            state_next = A_ADDSUB;
                        end
                    endcase
                end
            end
            A_ADDSUB:
            begin
                if (sum[DATA_W] != sum[DATA_W-1])
                begin
                    res_next = sum[DATA_W] ? Q_MIN : Q_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    res_next = sum[DATA_W-1:0];
                    sat_next = 1'b0;
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_MUL:
            begin
                p_next   = {sum[DATA_W:0], p_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS-1))
                    state_next = A_FIN;
            end
            A_DPRE:
            begin
                // upper dividend bits already reach the divisor: quotient >= 2^32
                if (qbit)
                begin
                    ovf_next   = 1'b1;
                    state_next = A_FIN;
                end
                else
                begin
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                if (qbit)
                    p_next = {sum[DATA_W-1:0], p_reg[DATA_W-2:0], 1'b1};
                else
                    p_next = {p_reg[2*DATA_W-2:DATA_W], p_reg[DATA_W-1],
                              p_reg[DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS-1))
                    state_next = A_FIN;
            end
            A_FIN:
            begin
                if (op_reg == ALU_MUL)
                begin
                    if (prod_sh[2*DATA_W-FRAC_W:DATA_W-1] == '0 ||
                        prod_sh[2*DATA_W-FRAC_W:DATA_W-1] == '1)
                    begin
                        res_next = prod_sh[DATA_W-1:0];
                        sat_next = 1'b0;
                    end
                    else
                    begin
                        res_next = prod_sh[2*DATA_W-FRAC_W] ? Q_MIN : Q_MAX;
                        sat_next = 1'b1;
                    end
                end
                else if (ovf_reg)
                begin
                    res_next = neg_reg ? Q_MIN : Q_MAX;
                    sat_next = 1'b1;
                end
                else if (!neg_reg && p_reg[DATA_W-1])
                begin
                    res_next = Q_MAX;
                    sat_next = 1'b1;
                end
                else if (neg_reg && p_reg[DATA_W-1] && (p_reg[DATA_W-2:0] != '0))
                begin
                    res_next = Q_MIN;
                    sat_next = 1'b1;
                end
                else
                begin
                    res_next = quo_s[DATA_W-1:0];
                    sat_next = 1'b0;
                end
                cnt_next   = '0;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        a_reg   <= a_next;
        p_reg   <= p_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    assign resp.done = done_reg;
    assign resp.sat  = sat_reg;
    assign result    = res_reg;

`ifndef SYNTH
    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("alu done held longer than one cycle");

    // a start is only given to an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == A_IDLE)
        else $error("alu started while busy");

    // the step counter only runs inside the loops
    a_cnt_loop: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> (state_reg == A_MUL || state_reg == A_DIV))
        else $error("alu step counter running outside a loop");
`endif

endmodule

### rtl/core/rpn_four_level_stack_alu_core.sv
// channel | dir | transfer moves
// --------+-----+-------------------------------------------------
// in      | in  | op, push_value: one stack command
// out     | out | x_reg, y_reg, z_reg, t_reg, status after a command
//
// push, invalid op and divide by zero complete at the input transfer itself.
// add/subtract take one pass of the shared 34-bit adder in rpnsa_alu; multiply
// and divide run its 32-step shift-add and restoring-divide loops, and divide
// ends early when the quotient is found to saturate before the loop.
// in.ready is low while the unit runs and while a result waits untaken.
// rst_n clears the stack to zero and empties the output register.
module rpn_four_level_stack_alu_core (
    input  logic        clk,
    input  logic        rst_n,
    rpnsa_in_if.sink    in,
    rpnsa_out_if.source out
);
    import rpnsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   stk_x_reg, stk_x_next;
    logic [DATA_W-1:0]   stk_y_reg, stk_y_next;
    logic [DATA_W-1:0]   stk_z_reg, stk_z_next;
    logic [DATA_W-1:0]   stk_t_reg, stk_t_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;

    logic                accept;
    logic                load;
    alu_req_t            req;
    alu_resp_t           resp;
    logic [DATA_W-1:0]   alu_result;

    rpnsa_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .y      (stk_y_reg),
        .x      (stk_x_reg),
        .resp   (resp),
        .result (alu_result)
    );

    // input handshake
    assign in.ready = (state_reg == S_IDLE) && (!out_valid_reg || out.ready);
    assign accept   = in.valid && in.ready;

    // stack control
    always_comb
    begin
        state_next  = state_reg;
        stk_x_next  = stk_x_reg;
        stk_y_next  = stk_y_reg;
        stk_z_next  = stk_z_reg;
        stk_t_next  = stk_t_reg;
        status_next = status_reg;
        load        = 1'b0;
        req.start   = 1'b0;
        req.op      = ALU_ADD;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in.op)
                        OP_PUSH:
                        begin
                            stk_t_next  = stk_z_reg;
                            stk_z_next  = stk_y_reg;
                            stk_y_next  = stk_x_reg;
                            stk_x_next  = in.push_value;
                            status_next = ST_OK;
                            load        = 1'b1;
                        end
                        OP_ADD:
                        begin
                            req.start  = 1'b1;
                            req.op     = ALU_ADD;
                            state_next = S_BUSY;
                        end
                        OP_SUB:
                        begin
                            req.start  = 1'b1;
                            req.op     = ALU_SUB;
                            state_next = S_BUSY;
                        end
                        OP_MUL:
                        begin
                            req.start  = 1'b1;
                            req.op     = ALU_MUL;
                            state_next = S_BUSY;
                        end
                        OP_DIV:
                        begin
                            if (stk_x_reg == '0)
                            begin
                                status_next = ST_DIV_ZERO;
                                load        = 1'b1;
                            end
                            else
                            begin
                                req.start  = 1'b1;
                                req.op     = ALU_DIV;
                                state_next = S_BUSY;
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                            load        = 1'b1;
                        end
                    endcase
                end
            end
            S_BUSY:
            begin
                if (resp.done)
                begin
                    stk_x_next  = alu_result;
                    stk_y_next  = stk_z_reg;
                    stk_z_next  = stk_t_reg;
                    stk_t_next  = '0;
                    status_next = resp.sat ? ST_SAT : ST_OK;
                    load        = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on a finished command, cleared by a transfer
    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            stk_x_reg     <= '0;
            stk_y_reg     <= '0;
            stk_z_reg     <= '0;
            stk_t_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            stk_x_reg     <= stk_x_next;
            stk_y_reg     <= stk_y_next;
            stk_z_reg     <= stk_z_next;
            stk_t_reg     <= stk_t_next;
            status_reg    <= status_next;
        end
    end

    // the stack itself is the output register
    assign out.valid  = out_valid_reg;
    assign out.x_reg  = stk_x_reg;
    assign out.y_reg  = stk_y_reg;
    assign out.z_reg  = stk_z_reg;
    assign out.t_reg  = stk_t_reg;
    assign out.status = status_reg;

`ifndef SYNTH
    // no input transfer while the unit runs
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BUSY |-> !in.ready)
        else $error("input accepted while arithmetic unit busy");

    // the unit only answers a command that is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        resp.done |-> state_reg == S_BUSY)
        else $error("arithmetic result without a pending command");

    // a push shows its result right after the transfer
    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in.op == OP_PUSH) |=> (out_valid_reg && status_reg == ST_OK))
        else $error("push result not presented");
`endif

endmodule

### tb/sv/rpn_four_level_stack_alu_core_test.sv
module rpn_four_level_stack_alu_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rpnsa_pkg::*;

    // op codes the block must reject
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic [DATA_W-1:0] Q_ONE      = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_NEG_UNIT = 32'hFFFF_FFFF;

    // Q16.16 range as wide signed bounds
    localparam longint Q_MAX_WIDE = 64'sd2147483647;
    localparam longint Q_MIN_WIDE = -64'sd2147483648;

    localparam int RANDOM_COMMANDS = 1025;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES = 400;

    // one snapshot of the stack as the output channel shows it
    typedef struct packed {
        logic [DATA_W-1:0]   x;
        logic [DATA_W-1:0]   y;
        logic [DATA_W-1:0]   z;
        logic [DATA_W-1:0]   t;
        logic [STATUS_W-1:0] status;
    } stack_view_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic              typed;
        stack_view_t       want;
    } command_row_t;

    logic clk;
    logic rst_n;

    rpnsa_in_if  in_ch ();
    rpnsa_out_if out_ch ();

    rpn_four_level_stack_alu_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    // predicted stack contents
    logic signed [DATA_W-1:0] stack_x;
    logic signed [DATA_W-1:0] stack_y;
    logic signed [DATA_W-1:0] stack_z;
    logic signed [DATA_W-1:0] stack_t;

    stack_view_t  pending_views[$];
    command_row_t directed_rows[$];

    int  error_count    = 0;
    int  results_seen   = 0;
    int  commands_taken = 0;
    int  cycle_count    = 0;
    int  op_count[8];
    int  status_count[4];
    bit  steady         = 1'b0;
    bit  hold_off       = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // clamp a wide result into the Q16.16 range
    function automatic logic [DATA_W-1:0] clamp_q(input longint v, output bit sat);
        sat = 1'b0;
        if (v > Q_MAX_WIDE)
        begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN_WIDE)
        begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // advance the predicted stack by one command and return what it shows
    function automatic stack_view_t apply_command(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] value);
        stack_view_t view;
        longint      lhs;
        longint      rhs;
        longint      wide;
        bit          sat;
        logic [STATUS_W-1:0] st;
        lhs  = longint'(stack_y);
        rhs  = longint'(stack_x);
        wide = 0;
        sat  = 1'b0;
        st   = ST_OK;
        case (op)
            OP_PUSH:
            begin
                stack_t = stack_z;
                stack_z = stack_y;
                stack_y = stack_x;
                stack_x = value;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (op == OP_DIV && rhs == 0)
                    st = ST_DIV_ZERO;
                else
                begin
                    case (op)
                        OP_ADD:  wide = lhs + rhs;
                        OP_SUB:  wide = lhs - rhs;
                        // arithmetic shift of the product floors toward minus infinity
                        OP_MUL:  wide = (lhs * rhs) >>> FRAC_W;
                        // integer division truncates toward zero
                        default: wide = (lhs * 65536) / rhs;
                    endcase
                    stack_x = clamp_q(wide, sat);
                    stack_y = stack_z;
                    stack_z = stack_t;
                    stack_t = '0;
                    if (sat)
                        st = ST_SAT;
                end
            end
            default:
                st = ST_INVALID;
        endcase
        view.x      = stack_x;
        view.y      = stack_y;
        view.z      = stack_z;
        view.t      = stack_t;
        view.status = st;
        return view;
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("mismatch on result %0d, %s: got %h, expected %h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // compare one output transfer with the oldest expectation
    task automatic check_result();
        stack_view_t want;
        results_seen++;
        if (pending_views.size() == 0)
        begin
            flag_mismatch("result with nothing expected", out_ch.x_reg, '0);
            return;
        end
        want = pending_views.pop_front();
        if (out_ch.x_reg !== want.x)
            flag_mismatch("x_reg", out_ch.x_reg, want.x);
        if (out_ch.y_reg !== want.y)
            flag_mismatch("y_reg", out_ch.y_reg, want.y);
        if (out_ch.z_reg !== want.z)
            flag_mismatch("z_reg", out_ch.z_reg, want.z);
        if (out_ch.t_reg !== want.t)
            flag_mismatch("t_reg", out_ch.t_reg, want.t);
        if (out_ch.status !== want.status)
            flag_mismatch("status", out_ch.status, want.status);
    endtask

    // offer one command, wait for its transfer, record the expected view
    task automatic issue_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                                 input logic typed, input stack_view_t typed_view);
        stack_view_t predicted;
        if (!steady && $urandom_range(99) < 26)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while (!steady && $urandom_range(99) < 26);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.push_value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = apply_command(op, value);
        pending_views.push_back(typed ? typed_view : predicted);
        op_count[op]++;
        status_count[predicted.status]++;
        commands_taken++;
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                           input logic typed, input logic [DATA_W-1:0] x,
                           input logic [DATA_W-1:0] y, input logic [DATA_W-1:0] z,
                           input logic [DATA_W-1:0] t, input logic [STATUS_W-1:0] st);
        command_row_t row;
        row.op     = op;
        row.value  = value;
        row.typed  = typed;
        row.want   = '{x: x, y: y, z: z, t: t, status: st};
        directed_rows.push_back(row);
    endtask

    // random push operand: full range, small fractions, extremes, zero, whole numbers
    function automatic logic [DATA_W-1:0] random_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 16 * 65536) - 8 * 65536;
            7:
            begin
                case ($urandom_range(5))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return 32'd1;
                    3:       return Q_NEG_UNIT;
                    4:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            8:          return '0;
            default:    return ($urandom_range(0, 200) - 100) << FRAC_W;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] random_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return OP_PUSH;
        if (roll < 52)
            return OP_ADD;
        if (roll < 64)
            return OP_SUB;
        if (roll < 76)
            return OP_MUL;
        if (roll < 90)
            return OP_DIV;
        return OP_W'($urandom_range(OP_RSVD_7, OP_RSVD_5));
    endfunction

    // output side: check transfers and idle ready at random
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                check_result();
            out_ch.ready <= !hold_off && (steady || $urandom_range(99) >= 26);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (commands_taken >= 700);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_views.size());
        $display("TB_ERROR");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        stack_view_t no_view;
        no_view = '0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= OP_PUSH;
        in_ch.push_value <= '0;
        stack_x = '0;
        stack_y = '0;
        stack_z = '0;
        stack_t = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, error codes, saturation at both bounds, T lost on push
        add_row(OP_ADD,    '0,         1, '0, '0, '0, '0, ST_OK);
        add_row(OP_DIV,    '0,         1, '0, '0, '0, '0, ST_DIV_ZERO);
        add_row(OP_RSVD_5, '0,         1, '0, '0, '0, '0, ST_INVALID);
        add_row(OP_RSVD_6, Q_MAX,      1, '0, '0, '0, '0, ST_INVALID);
        add_row(OP_RSVD_7, Q_NEG_UNIT, 1, '0, '0, '0, '0, ST_INVALID);
        add_row(OP_PUSH,   Q_MAX,      1, Q_MAX, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   Q_MAX,      1, Q_MAX, Q_MAX, '0, '0, ST_OK);
        add_row(OP_ADD,    '0,         1, Q_MAX, '0, '0, '0, ST_SAT);
        add_row(OP_PUSH,   Q_MIN,      1, Q_MIN, Q_MAX, '0, '0, ST_OK);
        add_row(OP_SUB,    '0,         1, Q_MAX, '0, '0, '0, ST_SAT);
        add_row(OP_PUSH,   Q_MIN,      0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   32'd1,      0, '0, '0, '0, '0, ST_OK);
        add_row(OP_SUB,    '0,         0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   Q_ONE,      0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   Q_NEG_UNIT, 0, '0, '0, '0, '0, ST_OK);
        add_row(OP_MUL,    Q_MAX,      0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   Q_MIN,      0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   Q_MIN,      0, '0, '0, '0, '0, ST_OK);
        add_row(OP_MUL,    '0,         0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   Q_NEG_UNIT, 0, '0, '0, '0, '0, ST_OK);
        add_row(OP_DIV,    '0,         0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   32'h0007_0000, 0, '0, '0, '0, '0, ST_OK);
        add_row(OP_DIV,    '0,         0, '0, '0, '0, '0, ST_OK);
        add_row(OP_PUSH,   '0,         0, '0, '0, '0, '0, ST_OK);
        add_row(OP_DIV,    Q_MIN,      0, '0, '0, '0, '0, ST_OK);

        foreach (directed_rows[i])
            issue_command(directed_rows[i].op, directed_rows[i].value,
                          directed_rows[i].typed, directed_rows[i].want);

        // random commands, with one stretch where neither side idles
        for (int i = 0; i < RANDOM_COMMANDS; i++)
        begin
            steady <= (i >= 350 && i < 550);
            issue_command(random_op(), random_operand(), 1'b0, no_view);
        end
        in_ch.valid <= 1'b0;
        steady      <= 1'b0;

        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d push, %0d add, %0d sub, %0d mul, %0d div, %0d bad op",
                 commands_taken, op_count[OP_PUSH], op_count[OP_ADD], op_count[OP_SUB],
                 op_count[OP_MUL], op_count[OP_DIV],
                 op_count[OP_RSVD_5] + op_count[OP_RSVD_6] + op_count[OP_RSVD_7]);
        $display("%0d saturated, %0d divide by zero; %0d results checked, %0d mismatches",
                 status_count[ST_SAT], status_count[ST_DIV_ZERO], results_seen, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
